### rtl/mbfs_pkg.sv
// package for the moving body frame step block: payload types, constants, trig table
package mbfs_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int TRIG_BITS_DEF  = 16;

    localparam logic [1:0] CMD_FREE    = 2'd0;
    localparam logic [1:0] CMD_FRAME   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [2:0] REG_START_X       = 3'd0;
    localparam logic [2:0] REG_START_Y       = 3'd1;
    localparam logic [2:0] REG_START_HEADING = 3'd2;
    localparam logic [2:0] REG_START_SPEED   = 3'd3;
    localparam logic [2:0] REG_ACCEL         = 3'd4;
    localparam logic [2:0] REG_TURN_RATE     = 3'd5;
    localparam logic [2:0] REG_TIME_STEP     = 3'd6;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic [15:0]        ref_heading;
        logic signed [31:0] ref_last_x;
        logic signed [31:0] ref_last_y;
        logic [15:0]        ref_last_heading;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading_out;
        logic               off_screen;
        logic [31:0]        age;
    } out_item_t;

    // quarter-wave sine, Q1.14, 33 entries
    function automatic logic [14:0] quarter_sine(input logic [5:0] k);
        logic [14:0] v;
        begin
            case (k)
                6'd0:  v = 15'd0;     6'd1:  v = 15'd804;   6'd2:  v = 15'd1606;
                6'd3:  v = 15'd2404;  6'd4:  v = 15'd3196;  6'd5:  v = 15'd3981;
                6'd6:  v = 15'd4756;  6'd7:  v = 15'd5520;  6'd8:  v = 15'd6270;
                6'd9:  v = 15'd7005;  6'd10: v = 15'd7723;  6'd11: v = 15'd8423;
                6'd12: v = 15'd9102;  6'd13: v = 15'd9760;  6'd14: v = 15'd10394;
                6'd15: v = 15'd11003; 6'd16: v = 15'd11585; 6'd17: v = 15'd12140;
                6'd18: v = 15'd12665; 6'd19: v = 15'd13160; 6'd20: v = 15'd13623;
                6'd21: v = 15'd14053; 6'd22: v = 15'd14449; 6'd23: v = 15'd14811;
                6'd24: v = 15'd15137; 6'd25: v = 15'd15426; 6'd26: v = 15'd15679;
                6'd27: v = 15'd15893; 6'd28: v = 15'd16069; 6'd29: v = 15'd16207;
                6'd30: v = 15'd16305; 6'd31: v = 15'd16364; 6'd32: v = 15'd16384;
                default: v = 15'd0;
            endcase
            return v;
        end
    endfunction

    // signed table value with 14 fraction bits for a 7-bit phase index
    function automatic logic signed [15:0] sine14(input logic [6:0] idx);
        logic [14:0] m;
        begin
            m = idx[5] ? quarter_sine(6'd32 - {1'b0, idx[4:0]}) : quarter_sine({1'b0, idx[4:0]});
            return idx[6] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        end
    endfunction

endpackage

### rtl/moving_body_frame_step_top.sv
// moving body frame step: sequencer around one shared signed multiplier
// throughput: one request at a time; ready returns the cycle after the result is loaded,
//   each product is registered, then consumed, on the single 36x22 multiplier; a held result stalls
// reset: asynchronous active low; pose, speed and age clear, cosine 1.0, time step 1.0
module moving_body_frame_step_top
    import mbfs_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int TRIG_BITS  = TRIG_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item
);

    localparam int TRIG_FRAC = TRIG_BITS - 2;
    localparam int AW        = ANGLE_BITS;
    localparam int TW        = TRIG_BITS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LEAVE = 4'd1;  // mul dx*c, dy*s, dy*c, dx*s
    localparam logic [3:0] ST_SPEED = 4'd2;  // mul accel*dt
    localparam logic [3:0] ST_TURN  = 4'd3;  // mul turn*dt
    localparam logic [3:0] ST_VEL   = 4'd4;  // mul speed*dt
    localparam logic [3:0] ST_MOVE  = 4'd5;  // mul v*c, v*s
    localparam logic [3:0] ST_ENTER = 4'd6;  // mul x*c, y*s, y*c, x*s
    localparam logic [3:0] ST_DONE  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    // converts table value to TRIG_FRAC fraction bits, rounding the magnitude
    function automatic logic signed [TW-1:0] trig_val(input logic [6:0] idx);
        logic signed [15:0] m14;
        logic signed [31:0] w;
        begin
            m14 = sine14(idx);
            w = idx[6] ? -32'(m14) : 32'(m14);
            if (TRIG_FRAC >= 14)
                w = w <<< (TRIG_FRAC >= 14 ? TRIG_FRAC - 14 : 0);
            else
                w = (w + (32'sd1 <<< ((TRIG_FRAC < 14 ? 14 - TRIG_FRAC : 1) - 1)))
                    >>> (TRIG_FRAC < 14 ? 14 - TRIG_FRAC : 1);
            if (idx[6])
                w = -w;
            return w[TW-1:0];
        end
    endfunction

    function automatic logic [6:0] ang_idx(input logic [AW-1:0] h);
        return h[AW-1 -: 7];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -40'sh0080000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    // config registers
    logic signed [31:0] start_x_reg, start_y_reg, start_speed_reg, accel_reg;
    logic [15:0]        start_heading_reg;
    logic signed [15:0] turn_rate_reg;
    logic [20:0]        time_step_reg;

    // body state
    logic signed [31:0] body_x_reg, body_y_reg, body_speed_reg;
    logic [AW-1:0]      body_heading_reg;
    logic signed [TW-1:0] sin_reg, cos_reg;
    logic               entered_reg;
    logic [31:0]        step_count_reg;

    // sequencer and work registers
    logic [3:0]         state_reg;
    logic [1:0]         sub_reg;
    in_item_t           req_reg;
    logic signed [35:0] va_reg, vb_reg;     // difference / velocity / pose operands
    logic signed [33:0] acc_reg;            // first result coordinate: shifted, saturated sum of two products
    logic signed [67:0] prod_reg;
    logic signed [TW-1:0] tc_reg, ts_reg;   // direction in use
    logic               prod_v_reg;
    out_item_t          out_reg;
    logic               out_v_reg;

    // shared multiplier operands
    logic signed [35:0]   mul_a;
    logic signed [21:0]   mul_b;
    logic signed [67:0]   mul_p;
    assign mul_p = 68'(mul_a) * 68'(mul_b);

    logic [CFG_DATA_W-1:0] cd;
    assign cd = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
            start_speed_reg   <= '0;
            accel_reg         <= '0;
            turn_rate_reg     <= '0;
            time_step_reg     <= 21'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X:       start_x_reg       <= cd[31:0];
                REG_START_Y:       start_y_reg       <= cd[31:0];
                REG_START_HEADING: start_heading_reg <= cd[15:0];
                REG_START_SPEED:   start_speed_reg   <= cd[31:0];
                REG_ACCEL:         accel_reg         <= cd[31:0];
                REG_TURN_RATE:     turn_rate_reg     <= cd[15:0];
                REG_TIME_STEP:     time_step_reg     <= cd[20:0];
                default: ;
            endcase
        end
    end

    // operand selection for the shared unit
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LEAVE, ST_MOVE, ST_ENTER:
            begin
                mul_a = (sub_reg == 2'd0 || sub_reg == 2'd3) ? va_reg : vb_reg;
                mul_b = (sub_reg == 2'd0 || sub_reg == 2'd2) ? 22'(tc_reg) : 22'(ts_reg);
            end
            ST_SPEED: begin mul_a = 36'(accel_reg);      mul_b = $signed({1'b0, time_step_reg}); end
            ST_TURN:  begin mul_a = 36'(turn_rate_reg);  mul_b = $signed({1'b0, time_step_reg}); end
            ST_VEL:   begin mul_a = 36'(body_speed_reg); mul_b = $signed({1'b0, time_step_reg}); end
            default: ;
        endcase
    end

    logic signed [67:0] t_pf;
    logic signed [67:0] t_pt;
    assign t_pf  = prod_reg >>> FRAC_BITS;
    assign t_pt  = prod_reg >>> TRIG_FRAC;

    logic signed [67:0] held_reg;   // first product of a pair
    logic signed [67:0] pair_sum;
    assign pair_sum = (sub_reg == 2'd1 || sub_reg == 2'd3) ?
                      ((state_reg == ST_ENTER && sub_reg == 2'd1) ||
                       (state_reg == ST_LEAVE && sub_reg == 2'd3) ?
                       held_reg - prod_reg : held_reg + prod_reg) : prod_reg;
    logic signed [67:0] pair_sh;
    assign pair_sh = pair_sum >>> TRIG_FRAC;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_v_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sub_reg          <= '0;
            prod_v_reg       <= 1'b0;
            out_v_reg        <= 1'b0;
            body_x_reg       <= '0;
            body_y_reg       <= '0;
            body_speed_reg   <= '0;
            body_heading_reg <= '0;
            sin_reg          <= '0;
            cos_reg          <= TW'(1) <<< TRIG_FRAC;
            entered_reg      <= 1'b0;
            step_count_reg   <= '0;
        end
        else
        begin
            if (out_v_reg && out_ready && state_reg != ST_DONE)
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= in_item;
                        sub_reg <= '0;
                        case (in_item.command)
                            CMD_RESTART:
                            begin
                                body_x_reg       <= start_x_reg;
                                body_y_reg       <= start_y_reg;
                                body_speed_reg   <= start_speed_reg;
                                body_heading_reg <= AW'(start_heading_reg);
                                sin_reg <= trig_val(ang_idx(AW'(start_heading_reg)));
                                cos_reg <= trig_val(ang_idx(AW'(start_heading_reg)) + 7'd32);
                                entered_reg      <= 1'b0;
                                step_count_reg   <= '0;
                                state_reg        <= ST_DONE;
                            end
                            CMD_FREE:
                            begin
                                sin_reg   <= trig_val(ang_idx(body_heading_reg));
                                cos_reg   <= trig_val(ang_idx(body_heading_reg) + 7'd32);
                                ts_reg    <= trig_val(ang_idx(body_heading_reg));
                                tc_reg    <= trig_val(ang_idx(body_heading_reg) + 7'd32);
                                state_reg <= ST_SPEED;
                            end
                            CMD_FRAME:
                            begin
                                ts_reg <= trig_val(ang_idx(AW'(in_item.ref_last_heading)));
                                tc_reg <= trig_val(ang_idx(AW'(in_item.ref_last_heading))
                                                   + 7'd32);
                                va_reg <= 36'(body_x_reg) - 36'(in_item.ref_last_x);
                                vb_reg <= 36'(body_y_reg) - 36'(in_item.ref_last_y);
                                entered_reg <= 1'b1;
                                state_reg <= entered_reg ? ST_LEAVE : ST_SPEED;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_SPEED, ST_TURN, ST_VEL:
                begin
                    // issue then consume one product
                    if (!prod_v_reg)
                    begin
                        prod_reg   <= mul_p;
                        prod_v_reg <= 1'b1;
                    end
                    else if (state_reg == ST_SPEED)
                    begin
                        prod_v_reg <= 1'b0;
                        body_speed_reg <= sat32(40'(body_speed_reg) + 40'(t_pf));
                        state_reg <= ST_TURN;
                    end
                    else if (state_reg == ST_TURN)
                    begin
                        prod_v_reg <= 1'b0;
                        body_heading_reg <= body_heading_reg + t_pf[AW-1:0];
                        state_reg <= ST_VEL;
                        if (req_reg.command == CMD_FRAME)
                        begin
                            ts_reg <= trig_val(ang_idx(body_heading_reg + t_pf[AW-1:0]));
                            tc_reg <= trig_val(ang_idx(body_heading_reg + t_pf[AW-1:0])
                                               + 7'd32);
                        end
                    end
                    else
                    begin
                        prod_v_reg <= 1'b0;
                        // speed*dt fits in 36 bits with dt at most 16.0
                        va_reg <= t_pf[35:0];
                        vb_reg <= t_pf[35:0];
                        sub_reg <= 2'd0;
                        state_reg <= ST_MOVE;
                    end
                end
                ST_LEAVE, ST_MOVE, ST_ENTER:
                begin
                    if (!prod_v_reg)
                    begin
                        prod_reg   <= mul_p;
                        prod_v_reg <= 1'b1;
                    end
                    else
                    begin
                        prod_v_reg <= 1'b0;
                        if (state_reg == ST_MOVE)
                        begin
                            // order: v*c, then v*s
                            if (sub_reg == 2'd0)
                            begin
                                body_x_reg <= sat32(40'(body_x_reg) + 40'(t_pt));
                                sub_reg <= 2'd1;
                            end
                            else
                            begin
                                body_y_reg <= sat32(40'(body_y_reg) + 40'(t_pt));
                                sub_reg <= 2'd0;
                                if (req_reg.command == CMD_FRAME)
                                begin
                                    // rotate the moved pose into the parent frame next
                                    va_reg <= 36'(body_x_reg);
                                    vb_reg <= 36'(sat32(40'(body_y_reg) + 40'(t_pt)));
                                    ts_reg <= trig_val(ang_idx(AW'(req_reg.ref_heading)));
                                    tc_reg <= trig_val(ang_idx(AW'(req_reg.ref_heading))
                                                       + 7'd32);
                                    state_reg <= ST_ENTER;
                                end
                                else
                                begin
                                    step_count_reg <= step_count_reg + {31'd0, step_count_reg != 32'hFFFFFFFF};
                                    state_reg <= ST_DONE;
                                end
                            end
                        end
                        else
                        begin
                            // sub 0: a*c, 1: +/- b*s ; 2: b*c, 3: -/+ a*s
                            // leave: x'= dx*c+dy*s, y'= dy*c-dx*s
                            // enter: x'= x*c-y*s+ref_x,  y'= y*c+x*s+ref_y
                            if (sub_reg == 2'd0 || sub_reg == 2'd2)
                                held_reg <= prod_reg;
                            else if (sub_reg == 2'd1)
                                acc_reg <= 34'(state_reg == ST_ENTER ?
                                           sat32(40'(pair_sh) + 40'(req_reg.ref_x)) :
                                           sat32(40'(pair_sh)));
                            sub_reg <= sub_reg + 2'd1;
                            if (sub_reg == 2'd3)
                            begin
                                body_x_reg <= acc_reg[31:0];
                                if (state_reg == ST_LEAVE)
                                begin
                                    body_y_reg <= sat32(40'(pair_sh));
                                    body_heading_reg <= body_heading_reg -
                                                        AW'(req_reg.ref_last_heading);
                                    state_reg <= ST_SPEED;
                                end
                                else
                                begin
                                    body_y_reg <= sat32(40'(pair_sh) + 40'(req_reg.ref_y));
                                    body_heading_reg <= body_heading_reg +
                                                        AW'(req_reg.ref_heading);
                                    sin_reg <= trig_val(ang_idx(body_heading_reg +
                                                                AW'(req_reg.ref_heading)));
                                    cos_reg <= trig_val(ang_idx(body_heading_reg +
                                                                AW'(req_reg.ref_heading))
                                                        + 7'd32);
                                    step_count_reg <= step_count_reg +
                                                      {31'd0, step_count_reg != 32'hFFFFFFFF};
                                    state_reg <= ST_DONE;
                                end
                            end
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!out_v_reg || out_ready)
                    begin
                        out_reg.pos_x       <= body_x_reg;
                        out_reg.pos_y       <= body_y_reg;
                        out_reg.heading_out <= 16'(body_heading_reg);
                        out_reg.off_screen  <=
                            (36'(body_x_reg) < -(36'sd10 <<< FRAC_BITS)) ||
                            (36'(body_x_reg) > (36'sd650 <<< FRAC_BITS)) ||
                            (36'(body_y_reg) < -(36'sd10 <<< FRAC_BITS)) ||
                            (36'(body_y_reg) > (36'sd490 <<< FRAC_BITS));
                        out_reg.age         <= step_count_reg;
                        out_v_reg           <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second request taken");
    a_restart_age: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.command == CMD_RESTART |=> step_count_reg == '0)
        else $error("restart age");

endmodule

### tb/tb_moving_body_frame_step_top.sv
// testbench for the moving body frame step block: random and directed steps against a predictor
`timescale 1ns / 100ps

module tb_moving_body_frame_step_top
    import mbfs_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_item;

    moving_body_frame_step_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    // predictor state and registers
    longint st_x, st_y, st_speed, acc, trate;
    int unsigned st_head, dt_q;
    longint bx, by, bspeed;
    int unsigned bhead;
    int sin_h, cos_h;
    bit entered;
    int unsigned steps;

    in_item_t  pending_requests[$];
    out_item_t expected_poses[$];
    int        errors;
    int        in_idle_pct;
    int        out_idle_pct;
    int        hold_out;
    bit        in_taken;

    function automatic int table_val(int unsigned idx);
        int m;
        m = (idx & 32) ? int'(quarter_sine(6'(32 - (idx & 31))))
                       : int'(quarter_sine(6'(idx & 31)));
        return (idx & 64) ? -m : m;
    endfunction

    function automatic void trig_of(int unsigned h, output int s, output int c);
        int unsigned idx;
        idx = (h & 16'hffff) >> 9;
        s = table_val(idx);
        c = table_val((idx + 32) & 127);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_START_X:       st_x = longint'($signed(v));
            REG_START_Y:       st_y = longint'($signed(v));
            REG_START_HEADING: st_head = v[15:0];
            REG_START_SPEED:   st_speed = longint'($signed(v));
            REG_ACCEL:         acc = longint'($signed(v));
            REG_TURN_RATE:     trate = longint'($signed(v[15:0]));
            REG_TIME_STEP:     dt_q = v[20:0];
            default: ;
        endcase
    endfunction

    function automatic void update_motion();
        longint d;
        d = longint'(dt_q);
        bspeed = clamp32(bspeed + ((acc * d) >>> 16));
        bhead = (bhead + int'((trate * d) >>> 16)) & 16'hffff;
    endfunction

    function automatic void advance(int c, int s);
        longint v;
        v = (bspeed * longint'(dt_q)) >>> 16;
        bx = clamp32(bx + ((v * c) >>> 14));
        by = clamp32(by + ((v * s) >>> 14));
    endfunction

    function automatic out_item_t predict_pose(in_item_t r);
        out_item_t o;
        int s, c;
        longint dx, dy, nx, ny;
        int unsigned lh;
        if (r.command == CMD_RESTART) begin
            bx = st_x; by = st_y; bspeed = st_speed; bhead = st_head;
            trig_of(bhead, sin_h, cos_h);
            entered = 0; steps = 0;
        end else if (r.command == CMD_FREE) begin
            trig_of(bhead, sin_h, cos_h);
            update_motion();
            advance(cos_h, sin_h);
            if (steps != 32'hffffffff) steps++;
        end else if (r.command == CMD_FRAME) begin
            if (entered) begin
                dx = bx - longint'(r.ref_last_x);
                dy = by - longint'(r.ref_last_y);
                lh = r.ref_last_heading;
                trig_of(lh, s, c);
                bx = clamp32((dx * c + dy * s) >>> 14);
                by = clamp32((dy * c - dx * s) >>> 14);
                bhead = (bhead - lh) & 16'hffff;
            end else
                entered = 1;
            update_motion();
            trig_of(bhead, s, c);
            advance(c, s);
            trig_of(r.ref_heading, s, c);
            nx = (bx * c - by * s) >>> 14;
            ny = (by * c + bx * s) >>> 14;
            bx = clamp32(nx + longint'(r.ref_x));
            by = clamp32(ny + longint'(r.ref_y));
            bhead = (bhead + r.ref_heading) & 16'hffff;
            trig_of(bhead, sin_h, cos_h);
            if (steps != 32'hffffffff) steps++;
        end
        o.pos_x = bx[31:0];
        o.pos_y = by[31:0];
        o.heading_out = bhead[15:0];
        o.off_screen = (bx < -(64'sd10 <<< 16)) || (bx > (64'sd650 <<< 16)) ||
                       (by < -(64'sd10 <<< 16)) || (by > (64'sd490 <<< 16));
        o.age = steps;
        return o;
    endfunction

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 700) << 16;
            3: return -($urandom_range(0, 20) << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t make_request(logic [1:0] cmd, bit near);
        in_item_t r;
        r.command = cmd;
        r.ref_x = near ? ($urandom_range(0, 640) << 16) : rnd32();
        r.ref_y = near ? ($urandom_range(0, 480) << 16) : rnd32();
        r.ref_heading = $urandom;
        r.ref_last_x = near ? r.ref_x + $signed($urandom_range(0, 8 << 16)) : rnd32();
        r.ref_last_y = near ? r.ref_y - $signed($urandom_range(0, 8 << 16)) : rnd32();
        r.ref_last_heading = $urandom;
        return r;
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // driver: a new request only after the current one was taken at the last rising edge
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 0;
            in_item <= '0;
        end else if (!in_valid || in_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
                in_valid <= 1;
                in_item <= pending_requests.pop_front();
            end else
                in_valid <= 0;
        end
    end

    always @(negedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ready <= 0;
        else if (hold_out > 0) begin
            out_ready <= 0;
            hold_out <= hold_out - 1;
        end else
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // predict on acceptance, check results
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_poses.push_back(predict_pose(in_item));
        if (rst_n && out_valid && out_ready) begin
            if (expected_poses.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $time, out_item);
            end else begin
                out_item_t e;
                e = expected_poses.pop_front();
                if (e.pos_x !== out_item.pos_x || e.pos_y !== out_item.pos_y ||
                    e.heading_out !== out_item.heading_out ||
                    e.off_screen !== out_item.off_screen || e.age !== out_item.age) begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        apply_reg(idx, v);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || in_valid || expected_poses.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_setting(int kind);
        write_reg(REG_START_X, kind == 0 ? 32'h7fffffff : kind == 1 ? 32'h80000000
                                          : ($urandom_range(0, 640) << 16));
        write_reg(REG_START_Y, kind == 0 ? 32'h80000000 : kind == 1 ? 32'h7fffffff
                                          : ($urandom_range(0, 480) << 16));
        write_reg(REG_START_HEADING, kind == 0 ? 32'hffff : $urandom_range(0, 65535));
        write_reg(REG_START_SPEED, kind == 0 ? 32'h7fffffff : kind == 1 ? 32'h80000000
                                   : $signed($urandom_range(0, 8 << 16)) - (4 << 16));
        write_reg(REG_ACCEL, kind == 0 ? 32'h7fffffff : kind == 1 ? 32'h80000000
                             : $urandom_range(0, 1 << 16) - (1 << 15));
        write_reg(REG_TURN_RATE, kind == 0 ? 32'h7fff : kind == 1 ? 32'h8000
                                 : $urandom_range(0, 65535));
        write_reg(REG_TIME_STEP, kind == 0 ? 32'h100000 : kind == 1 ? 32'h0
                                 : $urandom_range(0, 1 << 17));
    endtask

    initial begin
        in_item_t r;
        int n;
        errors = 0; hold_out = 0; in_taken = 0;
        in_idle_pct = 34; out_idle_pct = 34;
        st_x = 0; st_y = 0; st_speed = 0; acc = 0; trate = 0; st_head = 0; dt_q = 65536;
        bx = 0; by = 0; bspeed = 0; bhead = 0; entered = 0; steps = 0;
        trig_of(0, sin_h, cos_h);
        cfg_we = 0; cfg_index = '0; cfg_data = '0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n = 1;

        // directed: every command, unused command, frame entry, extremes
        r = make_request(CMD_FREE, 0);
        pending_requests.push_back(r);
        r.command = CMD_UNUSED; pending_requests.push_back(r);
        drain();
        random_setting(2);
        drain();
        random_setting(0);
        r = make_request(CMD_RESTART, 0); pending_requests.push_back(r);
        for (int i = 0; i < 6; i++) pending_requests.push_back(make_request(2'(i % 2), 0));
        r = '1; r.command = CMD_FRAME; pending_requests.push_back(r);
        r = '0; r.command = CMD_FRAME; pending_requests.push_back(r);
        drain();
        random_setting(1);
        r = make_request(CMD_RESTART, 0); pending_requests.push_back(r);
        for (int i = 0; i < 5; i++) pending_requests.push_back(make_request(2'(i % 2), 0));
        r.command = CMD_UNUSED; pending_requests.push_back(r);
        drain();

        // random phases; one with no idling, one with a long receiver hold
        for (int ph = 0; ph < 12; ph++) begin
            random_setting(ph < 2 ? ph : 2);
            in_idle_pct = (ph == 3) ? 0 : 34;
            out_idle_pct = (ph == 3) ? 0 : 34;
            pending_requests.push_back(make_request(CMD_RESTART, 0));
            for (int i = 0; i < 155; i++) begin
                n = $urandom_range(0, 99);
                if (n < 5) r = make_request(CMD_RESTART, 0);
                else if (n < 8) r = make_request(CMD_UNUSED, 0);
                else if (n < 55) r = make_request(CMD_FRAME, n < 50);
                else r = make_request(CMD_FREE, 0);
                pending_requests.push_back(r);
            end
            if (ph == 5) hold_out = 300;
            drain();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### moving_body_frame_step_top.f
rtl/mbfs_pkg.sv
rtl/moving_body_frame_step_top.sv
tb/tb_moving_body_frame_step_top.sv
